[hw/rtl/tcda_pkg.sv]
// Shared types, constants and helpers for the tile color distance argmin block.
`default_nettype none

package tcda_pkg;

  localparam int MAX_CANDIDATES = 1024;
  localparam int FRAC_BITS      = 4;

  localparam int CH_W    = 8;
  localparam int SQ_W    = 2 * CH_W + 2;              // sum of three squared 8-bit deltas
  localparam int V_W     = SQ_W + 2 * FRAC_BITS;      // radicand with fraction bits
  localparam int ROOT_W  = V_W / 2;
  localparam int REM_W   = ROOT_W + 3;
  localparam int DIST_W  = ROOT_W + 1;

  localparam int IDX_W   = 10;
  localparam int SUM_W   = 25;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam int COUNT_CAP = (MAX_CANDIDATES - 1 < 1023) ? MAX_CANDIDATES - 1 : 1023;

  localparam int QDEPTH  = 32;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [CH_W-1:0] target_red;
    logic [CH_W-1:0] target_green;
    logic [CH_W-1:0] target_blue;
    logic [CH_W-1:0] tile_red;
    logic [CH_W-1:0] tile_green;
    logic [CH_W-1:0] tile_blue;
    logic            last_pixel;
    logic            last_candidate;
  } pix_t;

  typedef struct packed {
    logic [IDX_W-1:0] best_index;
    logic [SUM_W-1:0] best_diff;
  } result_t;

  // One finished pixel distance with its framing marks.
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              last_pixel;
    logic              last_candidate;
  } work_t;

  function automatic logic [CH_W-1:0] absdiff(input logic [CH_W-1:0] a,
                                              input logic [CH_W-1:0] b);
    absdiff = (a > b) ? a - b : b - a;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/tile_color_distance_argmin.sv]
// Top level of the tile color distance argmin block: front end, queue and back end.
//
//   channel | direction | payload type      | handshake
//   pix     | in        | tcda_pkg::pix_t    | pix_valid / pix_ready
//   res     | out       | tcda_pkg::result_t | res_valid / res_ready
//
// Sustained rate is one pixel pair per cycle while a queue slot is free; the front end is a
// 15-stage pipeline (squares, 13 square root stages, rounding), each distance then passes
// through the registered queue, and the back end loads the result into its result register.
// Reset is synchronous and clears all control state; there is no clearing pass.
// The 32-entry queue absorbs stalls on the result side; pix_ready drops only once
// 32 pairs are held between the front end and the back end.
`default_nettype none

module tile_color_distance_argmin (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              pix_valid,
  output logic                   pix_ready,
  input  wire tcda_pkg::pix_t    pix,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output tcda_pkg::result_t      res
);

  logic             dst_valid;
  tcda_pkg::work_t  dst;
  logic             q_valid;
  logic             q_ready;
  tcda_pkg::work_t  q_item;

  tcda_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .q_pop     (q_valid && q_ready),
    .dst_valid (dst_valid),
    .dst       (dst)
  );

  tcda_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (dst_valid),
    .push_item  (dst),
    .head_valid (q_valid),
    .head_ready (q_ready),
    .head_item  (q_item)
  );

  tcda_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

`default_nettype wire

[hw/rtl/tcda_front.sv]
// Front end: squared color deltas and a bit-per-stage pipelined rounded square root.
`default_nettype none

module tcda_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            pix_valid,
  output logic                 pix_ready,
  input  wire tcda_pkg::pix_t  pix,
  input  wire logic            q_pop,
  output logic                 dst_valid,
  output tcda_pkg::work_t      dst
);

  localparam int NSTG = tcda_pkg::ROOT_W;

  logic [tcda_pkg::QCNT_W-1:0] used;
  logic [tcda_pkg::QCNT_W-1:0] used_next;
  logic                        accept;

  logic [tcda_pkg::CH_W-1:0] d_r, d_g, d_b;
  logic [2*tcda_pkg::CH_W-1:0] sq_r, sq_g, sq_b;
  logic [tcda_pkg::SQ_W-1:0] sq_sum;

  logic [NSTG:0]                stg_valid;
  logic [tcda_pkg::V_W-1:0]     stg_v    [NSTG+1];
  logic [tcda_pkg::ROOT_W-1:0]  stg_root [NSTG+1];
  logic [tcda_pkg::REM_W-1:0]   stg_rem  [NSTG+1];
  logic [NSTG:0]                stg_lp;
  logic [NSTG:0]                stg_lc;

  logic [tcda_pkg::REM_W-1:0]   rem_in   [NSTG];
  logic [tcda_pkg::REM_W-1:0]   trial    [NSTG];
  logic [NSTG-1:0]              bit_ok;

  logic                         rnd_up;

  // Every item inside the pipeline or in the queue holds one slot, so the queue never overflows.
  assign pix_ready = (used != tcda_pkg::QCNT_W'(tcda_pkg::QDEPTH));
  assign accept    = pix_valid && pix_ready;

  always_comb begin
    used_next = used;
    if (accept && !q_pop) begin
      used_next = used + 1'b1;
    end else if (!accept && q_pop) begin
      used_next = used - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      used <= used_next;
    end
  end

  assign d_r    = tcda_pkg::absdiff(pix.target_red,   pix.tile_red);
  assign d_g    = tcda_pkg::absdiff(pix.target_green, pix.tile_green);
  assign d_b    = tcda_pkg::absdiff(pix.target_blue,  pix.tile_blue);
  assign sq_r   = (2*tcda_pkg::CH_W)'(d_r) * (2*tcda_pkg::CH_W)'(d_r);
  assign sq_g   = (2*tcda_pkg::CH_W)'(d_g) * (2*tcda_pkg::CH_W)'(d_g);
  assign sq_b   = (2*tcda_pkg::CH_W)'(d_b) * (2*tcda_pkg::CH_W)'(d_b);
  assign sq_sum = tcda_pkg::SQ_W'(sq_r) + tcda_pkg::SQ_W'(sq_g) + tcda_pkg::SQ_W'(sq_b);

  // Each stage brings down the next two radicand bits and settles one root bit.
  always_comb begin
    for (int k = 0; k < NSTG; k++) begin
      rem_in[k] = {stg_rem[k][tcda_pkg::REM_W-3:0], stg_v[k][tcda_pkg::V_W-1 -: 2]};
      trial[k]  = tcda_pkg::REM_W'({stg_root[k], 2'b01});
      bit_ok[k] = (rem_in[k] >= trial[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= '0;
      dst_valid <= 1'b0;
    end else begin
      stg_valid <= {stg_valid[NSTG-1:0], accept};
      dst_valid <= stg_valid[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    stg_v[0]    <= {sq_sum, {(2*tcda_pkg::FRAC_BITS){1'b0}}};
    stg_root[0] <= '0;
    stg_rem[0]  <= '0;
    stg_lp[0]   <= pix.last_pixel;
    stg_lc[0]   <= pix.last_candidate;
    for (int k = 0; k < NSTG; k++) begin
      stg_v[k+1]    <= stg_v[k] << 2;
      stg_root[k+1] <= {stg_root[k][tcda_pkg::ROOT_W-2:0], bit_ok[k]};
      stg_rem[k+1]  <= bit_ok[k] ? rem_in[k] - trial[k] : rem_in[k];
      stg_lp[k+1]   <= stg_lp[k];
      stg_lc[k+1]   <= stg_lc[k];
    end
    dst.distance       <= tcda_pkg::DIST_W'(stg_root[NSTG]) + tcda_pkg::DIST_W'(rnd_up);
    dst.last_pixel     <= stg_lp[NSTG];
    dst.last_candidate <= stg_lc[NSTG];
  end

  // The remainder is v - r*r; above r the true root lies nearer r+1.
  assign rnd_up = (stg_rem[NSTG] > tcda_pkg::REM_W'(stg_root[NSTG]));

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= tcda_pkg::QCNT_W'(tcda_pkg::QDEPTH))
    else $error("front slot count above queue depth");

  a_inflight_counted: assert property (@(posedge clk) disable iff (rst)
    ($countones(stg_valid) + $countones(dst_valid)) <= used)
    else $error("items in the pipeline exceed held slots");

  a_no_pop_when_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (used != '0))
    else $error("queue pop without any held slot");

endmodule

`default_nettype wire

[hw/rtl/tcda_queue.sv]
// Register queue that carries pixel distances from the front end to the back end.
`default_nettype none

module tcda_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire tcda_pkg::work_t  push_item,
  output logic                  head_valid,
  input  wire logic             head_ready,
  output tcda_pkg::work_t       head_item
);

  tcda_pkg::work_t               slots [tcda_pkg::QDEPTH];
  logic [tcda_pkg::QPTR_W-1:0]   wr_ptr;
  logic [tcda_pkg::QPTR_W-1:0]   rd_ptr;
  logic [tcda_pkg::QCNT_W-1:0]   count;
  logic                          pop;

  assign head_valid = (count != '0);
  assign head_item  = slots[rd_ptr];
  assign pop        = head_valid && head_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != tcda_pkg::QCNT_W'(tcda_pkg::QDEPTH)) || pop)
    else $error("queue written while full");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= tcda_pkg::QCNT_W'(tcda_pkg::QDEPTH))
    else $error("queue count above depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == tcda_pkg::QCNT_W'(tcda_pkg::QDEPTH)) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

[hw/rtl/tcda_back.sv]
// Back end: saturating per-candidate sum, running argmin and the result register.
`default_nettype none

module tcda_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  output logic                  q_ready,
  input  wire tcda_pkg::work_t  q_item,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output tcda_pkg::result_t     res
);

  logic [tcda_pkg::SUM_W-1:0] running_sum;
  logic [tcda_pkg::SUM_W-1:0] best_sum;
  logic [tcda_pkg::IDX_W-1:0] best_candidate;
  logic [tcda_pkg::IDX_W-1:0] candidate_count;
  logic                       have_best;

  logic                       ends_block;
  logic                       pop;
  logic [tcda_pkg::SUM_W:0]   acc;
  logic [tcda_pkg::SUM_W-1:0] sum_sat;
  logic                       take;
  logic [tcda_pkg::SUM_W-1:0] win_sum;
  logic [tcda_pkg::IDX_W-1:0] win_idx;

  assign ends_block = q_item.last_pixel && q_item.last_candidate;
  // Only a block-closing transfer needs the result register free.
  assign q_ready    = !ends_block || !res_valid || res_ready;
  assign pop        = q_valid && q_ready;

  assign acc     = {1'b0, running_sum} + (tcda_pkg::SUM_W + 1)'(q_item.distance);
  assign sum_sat = acc[tcda_pkg::SUM_W] ? tcda_pkg::SUM_MAX : acc[tcda_pkg::SUM_W-1:0];
  assign take    = !have_best || (sum_sat < best_sum);
  assign win_sum = take ? sum_sat : best_sum;
  assign win_idx = take ? candidate_count : best_candidate;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum     <= '0;
      best_sum        <= '0;
      best_candidate  <= '0;
      candidate_count <= '0;
      have_best       <= 1'b0;
      res_valid       <= 1'b0;
    end else begin
      if (res_valid && res_ready && !(pop && ends_block)) begin
        res_valid <= 1'b0;
      end
      if (pop) begin
        if (!q_item.last_pixel) begin
          running_sum <= sum_sat;
        end else begin
          running_sum <= '0;
          if (q_item.last_candidate) begin
            res_valid       <= 1'b1;
            best_sum        <= '0;
            best_candidate  <= '0;
            candidate_count <= '0;
            have_best       <= 1'b0;
          end else begin
            best_sum       <= win_sum;
            best_candidate <= win_idx;
            have_best      <= 1'b1;
            if (candidate_count < tcda_pkg::IDX_W'(tcda_pkg::COUNT_CAP)) begin
              candidate_count <= candidate_count + 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && ends_block) begin
      res.best_index <= win_idx;
      res.best_diff  <= win_sum;
    end
  end

  a_close_loads_result: assert property (@(posedge clk) disable iff (rst)
    (pop && ends_block) |=> res_valid)
    else $error("closing transfer did not load a result");

  a_close_clears_state: assert property (@(posedge clk) disable iff (rst)
    (pop && ends_block) |=> (candidate_count == '0) && !have_best && (running_sum == '0))
    else $error("state not cleared after a block closed");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    candidate_count <= tcda_pkg::IDX_W'(tcda_pkg::COUNT_CAP))
    else $error("candidate count beyond its cap");

endmodule

`default_nettype wire
